FILE: rtl/core/dwvs_pkg.sv
// Package: shared types, codes and constants of the dual wheel velocity servo.
`timescale 1ns / 1ps
package dwvs_pkg;

	localparam int WHEEL_COUNT = 2;
	localparam int KIND_COUNT  = 15;
	localparam int CPL_COUNT   = 6;
	localparam logic [31:0] WDOG_RESET_LIMIT = 32'd100;

	// Coefficient kinds, in write code order
	localparam int K_KI         = 0;
	localparam int K_KV         = 1;
	localparam int K_FR_PLUS    = 2;
	localparam int K_FR_WPLUS   = 3;
	localparam int K_FR_MINUS   = 4;
	localparam int K_FR_WMINUS  = 5;
	localparam int K_PI_KP      = 6;
	localparam int K_PI_KI      = 7;
	localparam int K_PWM_MAX    = 8;
	localparam int K_PWM_MIN    = 9;
	localparam int K_TOQ_MAX    = 10;
	localparam int K_TOQ_MIN    = 11;
	localparam int K_TOQ_OFFSET = 12;
	localparam int K_INT_MAX    = 13;
	localparam int K_INT_MIN    = 14;

	// Parameter write codes
	localparam logic [7:0] PC_TARGET    = 8'd0;
	localparam logic [7:0] PC_WHEEL_LO  = 8'd1;
	localparam logic [7:0] PC_WHEEL_HI  = 8'd6;
	localparam logic [7:0] PC_CPL_LO    = 8'd7;
	localparam logic [7:0] PC_CPL_HI    = 8'd12;
	localparam logic [7:0] PC_PI_LO     = 8'd13;
	localparam logic [7:0] PC_PI_HI     = 8'd21;
	localparam logic [7:0] PC_LEVEL     = 8'd22;
	localparam logic [7:0] PC_WDOG      = 8'd23;

	localparam logic [1:0] LVL_STOP  = 2'd0;
	localparam logic [1:0] LVL_HOLD  = 2'd1;
	localparam logic [1:0] LVL_TORQ  = 2'd2;
	localparam logic [1:0] LVL_VEL   = 2'd3;

	typedef struct packed {
		logic              mode;
		logic signed [15:0] speed_left;
		logic signed [15:0] speed_right;
		logic [7:0]        param_code;
		logic [7:0]        motor_index;
		logic signed [31:0] param_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pwm_left;
		logic signed [31:0] pwm_right;
		logic              drive_written;
		logic [1:0]        level_now;
		logic              timed_out;
	} res_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ERR, OP_MKP, OP_MKI, OP_SUM,
		OP_FRIC, OP_COMP, OP_CLIP, OP_MKT, OP_MKV, OP_DIV, OP_PWM
	} lane_op_t;

	typedef enum logic [2:0] {
		MG_NONE, MG_P1, MG_P2, MG_P3, MG_SUM
	} mrg_op_t;

	typedef struct packed {
		lane_op_t op;
		logic     level3;
		logic     integ_clr;
		logic     drive_clr;
	} lane_ctl_t;

	typedef logic [KIND_COUNT-1:0][31:0] lane_coef_t;

endpackage

FILE: rtl/core/dwvs_cmd_if.sv
// Interface: command item channel.
`timescale 1ns / 1ps
interface dwvs_cmd_if;
	logic valid;
	logic ready;
	dwvs_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/dwvs_res_if.sv
// Interface: result item channel.
`timescale 1ns / 1ps
interface dwvs_res_if;
	logic valid;
	logic ready;
	dwvs_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/dwvs_lane.sv
// Module: per-wheel servo lane (PI, friction, torque clip, PWM conversion).
`timescale 1ns / 1ps
module dwvs_lane (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dwvs_pkg::lane_ctl_t      ctl,
	input  dwvs_pkg::lane_coef_t     coef,
	input  logic [31:0]              spd,
	input  logic [31:0]              tgt,
	input  logic [31:0]              diff,
	input  logic [31:0]              toq_in,
	output logic [31:0]              s_out,
	output logic [31:0]              drive
);

	logic [31:0] integ_q, drive_q;
	logic [31:0] err_q, m_q, acc_q, toq_q, s_q;
	logic [31:0] err_c, integ_sum, integ_c1, integ_c2;
	logic [31:0] comp_c, clip_c1, clip_c2, div_in, div_c, hi_c, lo_c, pwm_c1, pwm_c2;
	logic [63:0] prod_c;
	logic [31:0] mul_a, mul_b;
	logic        spd_pos, spd_neg;

	assign spd_pos = ($signed(spd) > 0);
	assign spd_neg = spd[31];

	// Integrator update with clamp, max first then min
	always_comb begin
		err_c     = tgt - spd;
		integ_sum = integ_q + err_c;
		integ_c1  = ($signed(integ_sum) > $signed(coef[dwvs_pkg::K_INT_MAX])) ?
			coef[dwvs_pkg::K_INT_MAX] : integ_sum;
		integ_c2  = ($signed(integ_c1) < $signed(coef[dwvs_pkg::K_INT_MIN])) ?
			coef[dwvs_pkg::K_INT_MIN] : integ_c1;
	end

	// Select the operands of the one lane multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.op)
			dwvs_pkg::OP_MKP: begin mul_a = err_q; mul_b = coef[dwvs_pkg::K_PI_KP]; end
			dwvs_pkg::OP_MKI: begin mul_a = integ_q; mul_b = coef[dwvs_pkg::K_PI_KI]; end
			dwvs_pkg::OP_FRIC: begin
				mul_a = spd_neg ? (32'd0 - spd) : spd;
				mul_b = spd_neg ? coef[dwvs_pkg::K_FR_WMINUS] : coef[dwvs_pkg::K_FR_WPLUS];
			end
			dwvs_pkg::OP_MKT: begin mul_a = toq_q; mul_b = coef[dwvs_pkg::K_KI]; end
			dwvs_pkg::OP_MKV: begin mul_a = spd; mul_b = coef[dwvs_pkg::K_KV]; end
			default: ;
		endcase
		prod_c = mul_a * mul_b;
	end

	// Friction and offset compensation, torque clip, PWM conversion and clip
	always_comb begin
		if (spd_pos)
			comp_c = toq_q + m_q + coef[dwvs_pkg::K_FR_PLUS] + coef[dwvs_pkg::K_TOQ_OFFSET];
		else if (spd_neg)
			comp_c = toq_q - (m_q + coef[dwvs_pkg::K_FR_MINUS]) + coef[dwvs_pkg::K_TOQ_OFFSET];
		else
			comp_c = toq_q + coef[dwvs_pkg::K_TOQ_OFFSET];
		clip_c1 = ($signed(toq_q) >= $signed(coef[dwvs_pkg::K_TOQ_MAX])) ?
			coef[dwvs_pkg::K_TOQ_MAX] : toq_q;
		clip_c2 = ($signed(clip_c1) <= $signed(coef[dwvs_pkg::K_TOQ_MIN])) ?
			coef[dwvs_pkg::K_TOQ_MIN] : clip_c1;
		div_in = acc_q + m_q;
		div_c  = div_in[31] ? (32'd0 - ((32'd0 - div_in) >> 16)) : (div_in >> 16);
		hi_c   = coef[dwvs_pkg::K_PWM_MAX] - 32'd1;
		lo_c   = coef[dwvs_pkg::K_PWM_MIN] + 32'd1;
		pwm_c1 = ($signed(acc_q) > $signed(hi_c)) ? hi_c : acc_q;
		pwm_c2 = ($signed(pwm_c1) < $signed(lo_c)) ? lo_c : pwm_c1;
	end

	// Datapath registers, advanced by the op code
	always_ff @(posedge clk) begin
		case (ctl.op)
			dwvs_pkg::OP_ERR: err_q <= err_c;
			dwvs_pkg::OP_MKP: m_q <= prod_c[31:0];
			dwvs_pkg::OP_MKI: begin acc_q <= m_q; m_q <= prod_c[31:0]; end
			dwvs_pkg::OP_SUM: s_q <= acc_q + m_q + diff;
			dwvs_pkg::OP_FRIC: begin
				toq_q <= ctl.level3 ? toq_in : 32'd0;
				m_q   <= prod_c[31:0];
			end
			dwvs_pkg::OP_COMP: toq_q <= comp_c;
			dwvs_pkg::OP_CLIP: toq_q <= clip_c2;
			dwvs_pkg::OP_MKT: m_q <= prod_c[31:0];
			dwvs_pkg::OP_MKV: begin acc_q <= m_q; m_q <= prod_c[31:0]; end
			dwvs_pkg::OP_DIV: acc_q <= div_c;
			default: ;
		endcase
	end

	// Integrator and drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			drive_q <= '0;
		end else begin
			if (ctl.integ_clr)
				integ_q <= '0;
			else if (ctl.op == dwvs_pkg::OP_ERR)
				integ_q <= integ_c2;
			if (ctl.drive_clr)
				drive_q <= '0;
			else if (ctl.op == dwvs_pkg::OP_PWM)
				drive_q <= pwm_c2;
		end
	end

	assign s_out = s_q;
	assign drive = drive_q;

endmodule

FILE: rtl/core/dwvs_merge.sv
// Module: cross-coupled feedforward merge of the two lane sums.
`timescale 1ns / 1ps
module dwvs_merge (
	input  logic                clk,
	input  dwvs_pkg::mrg_op_t   op,
	input  logic [31:0]         sa,
	input  logic [31:0]         sb,
	input  logic [31:0]         at0,
	input  logic [31:0]         at1,
	input  logic [dwvs_pkg::CPL_COUNT-1:0][31:0] cpl,
	output logic [31:0]         toq0,
	output logic [31:0]         toq1
);

	logic [31:0] a0, b0, a1, b1;
	logic [63:0] p0_c, p1_c;
	logic [31:0] p0_q, p1_q, acc0_q, acc1_q, toq0_q, toq1_q;
	logic [31:0] sum0, sum1;

	// Pick one product per wheel for this step
	always_comb begin
		a0 = '0; b0 = '0; a1 = '0; b1 = '0;
		case (op)
			dwvs_pkg::MG_P1: begin a0 = sa; b0 = cpl[0]; a1 = sb; b1 = cpl[1]; end
			dwvs_pkg::MG_P2: begin a0 = sb; b0 = cpl[2]; a1 = sa; b1 = cpl[3]; end
			dwvs_pkg::MG_P3: begin a0 = at0; b0 = cpl[4]; a1 = at1; b1 = cpl[5]; end
			default: ;
		endcase
		p0_c = a0 * b0;
		p1_c = a1 * b1;
		sum0 = acc0_q + p0_q;
		sum1 = acc1_q + p1_q;
	end

	// Accumulate, then shift right by 8 arithmetically
	always_ff @(posedge clk) begin
		case (op)
			dwvs_pkg::MG_P1: begin
				p0_q <= p0_c[31:0]; p1_q <= p1_c[31:0];
				acc0_q <= '0; acc1_q <= '0;
			end
			dwvs_pkg::MG_P2, dwvs_pkg::MG_P3: begin
				p0_q <= p0_c[31:0]; p1_q <= p1_c[31:0];
				acc0_q <= sum0; acc1_q <= sum1;
			end
			dwvs_pkg::MG_SUM: begin
				toq0_q <= {{8{sum0[31]}}, sum0[31:8]};
				toq1_q <= {{8{sum1[31]}}, sum1[31:8]};
			end
			default: ;
		endcase
	end

	assign toq0 = toq0_q;
	assign toq1 = toq1_q;

endmodule

FILE: rtl/core/dual_wheel_velocity_servo_unit.sv
// A write item or a tick at level 0 or 1 gives its result in the cycle after acceptance.
// A level 2 tick steps through S_FIN and then S_OUT; a level 3 tick first runs S_PI and
// the 4-step coupling merge S_MRG. Each lane multiplier forms one 32x32 product per cycle.
// One item is in work at a time; the next is taken once the result register frees.
// Reset (arst_n low, asynchronous) clears settings and control state; watchdog limit is 100.
`timescale 1ns / 1ps
module dual_wheel_velocity_servo_unit (
	input  logic        clk,
	input  logic        arst_n,
	dwvs_cmd_if.sink    cmd,
	dwvs_res_if.source  res
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PI   = 5'b00010,
		S_MRG  = 5'b00100,
		S_FIN  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [2:0] step_q;

	logic [dwvs_pkg::WHEEL_COUNT-1:0][dwvs_pkg::KIND_COUNT-1:0][31:0] coef_q;
	logic [dwvs_pkg::CPL_COUNT-1:0][31:0] cpl_q;
	logic [dwvs_pkg::WHEEL_COUNT-1:0][31:0] pend_q, act_q, prev_q, diff_q, spd_q;
	logic [1:0]  flags_q, level_q;
	logic [31:0] wdog_cnt_q, wdog_lim_q;
	logic        level3_q, out_v_q, integ_clr, drive_clr, accept, wr_ok, expire;
	logic        out_load;
	dwvs_pkg::res_t out_q;
	dwvs_pkg::lane_op_t lop;
	dwvs_pkg::mrg_op_t  mop;
	dwvs_pkg::lane_ctl_t ctl;
	logic [dwvs_pkg::WHEEL_COUNT-1:0][31:0] s_w, drive_w, toq_w, act_next;
	logic [31:0] wdog_inc;
	logic [1:0]  lvl_wr;
	logic        wheel;

	assign cmd.ready = (state_q == S_IDLE) && (!out_v_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign wheel     = cmd.data.motor_index[0];
	assign wr_ok     = (cmd.data.motor_index[7:1] == 7'd0) &&
		(cmd.data.param_code <= dwvs_pkg::PC_WDOG);
	assign wdog_inc  = wdog_cnt_q + 32'd1;
	assign expire    = ($signed(wdog_inc) > $signed(wdog_lim_q));

	// Clamp a level write to 0..3
	always_comb begin
		if (cmd.data.param_value[31])
			lvl_wr = dwvs_pkg::LVL_STOP;
		else if (cmd.data.param_value[30:2] != 29'd0)
			lvl_wr = dwvs_pkg::LVL_VEL;
		else
			lvl_wr = cmd.data.param_value[1:0];
	end

	assign act_next  = (flags_q == 2'b11) ? pend_q : act_q;
	assign integ_clr = accept && cmd.data.mode && wr_ok &&
		(cmd.data.param_code == dwvs_pkg::PC_LEVEL) &&
		(level_q != dwvs_pkg::LVL_VEL) && (lvl_wr == dwvs_pkg::LVL_VEL);
	assign drive_clr = accept && !cmd.data.mode && (level_q == dwvs_pkg::LVL_STOP);

	// Load the result register on a write, a short tick or the end of a long tick
	assign out_load = (accept && (cmd.data.mode || level_q == dwvs_pkg::LVL_STOP ||
		level_q == dwvs_pkg::LVL_HOLD)) || (state_q == S_OUT);

	// Decode the sequencer step into lane and merge ops
	always_comb begin
		lop = dwvs_pkg::OP_NONE;
		mop = dwvs_pkg::MG_NONE;
		unique case (state_q)
			S_PI: begin
				unique case (step_q)
					3'd0: lop = dwvs_pkg::OP_ERR;
					3'd1: lop = dwvs_pkg::OP_MKP;
					3'd2: lop = dwvs_pkg::OP_MKI;
					default: lop = dwvs_pkg::OP_SUM;
				endcase
			end
			S_MRG: begin
				unique case (step_q)
					3'd0: mop = dwvs_pkg::MG_P1;
					3'd1: mop = dwvs_pkg::MG_P2;
					3'd2: mop = dwvs_pkg::MG_P3;
					default: mop = dwvs_pkg::MG_SUM;
				endcase
			end
			S_FIN: begin
				unique case (step_q)
					3'd0: lop = dwvs_pkg::OP_FRIC;
					3'd1: lop = dwvs_pkg::OP_COMP;
					3'd2: lop = dwvs_pkg::OP_CLIP;
					3'd3: lop = dwvs_pkg::OP_MKT;
					3'd4: lop = dwvs_pkg::OP_MKV;
					3'd5: lop = dwvs_pkg::OP_DIV;
					default: lop = dwvs_pkg::OP_PWM;
				endcase
			end
			default: ;
		endcase
		ctl.op        = lop;
		ctl.level3    = level3_q;
		ctl.integ_clr = integ_clr;
		ctl.drive_clr = drive_clr;
	end

	// Wheel lanes
	for (genvar i = 0; i < dwvs_pkg::WHEEL_COUNT; i++) begin : g_lane
		dwvs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.coef   (coef_q[i]),
			.spd    (spd_q[i]),
			.tgt    (act_q[i]),
			.diff   (diff_q[i]),
			.toq_in (toq_w[i]),
			.s_out  (s_w[i]),
			.drive  (drive_w[i])
		);
	end

	dwvs_merge u_merge (
		.clk  (clk),
		.op   (mop),
		.sa   (s_w[0]),
		.sb   (s_w[1]),
		.at0  (act_q[0]),
		.at1  (act_q[1]),
		.cpl  (cpl_q),
		.toq0 (toq_w[0]),
		.toq1 (toq_w[1])
	);

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_load)
			out_v_q <= 1'b1;
		else if (res.valid && res.ready)
			out_v_q <= 1'b0;
	end

	// Settings, targets, watchdog and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			coef_q     <= '0;
			cpl_q      <= '0;
			pend_q     <= '0;
			act_q      <= '0;
			prev_q     <= '0;
			diff_q     <= '0;
			spd_q      <= '0;
			flags_q    <= '0;
			level_q    <= dwvs_pkg::LVL_STOP;
			level3_q   <= 1'b0;
			wdog_cnt_q <= '0;
			wdog_lim_q <= dwvs_pkg::WDOG_RESET_LIMIT;
			out_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd.data.mode) begin
						// Parameter write
						if (wr_ok) begin
							if (cmd.data.param_code == dwvs_pkg::PC_TARGET) begin
								pend_q[wheel]  <= cmd.data.param_value;
								flags_q[wheel] <= 1'b1;
							end else if (cmd.data.param_code <= dwvs_pkg::PC_WHEEL_HI) begin
								coef_q[wheel][4'(cmd.data.param_code - dwvs_pkg::PC_WHEEL_LO)]
									<= cmd.data.param_value;
							end else if (cmd.data.param_code <= dwvs_pkg::PC_CPL_HI) begin
								cpl_q[3'(cmd.data.param_code - dwvs_pkg::PC_CPL_LO)]
									<= cmd.data.param_value;
							end else if (cmd.data.param_code <= dwvs_pkg::PC_PI_HI) begin
								coef_q[wheel][4'(cmd.data.param_code - dwvs_pkg::PC_PI_LO
									+ 8'(dwvs_pkg::K_PI_KP))] <= cmd.data.param_value;
							end else if (cmd.data.param_code == dwvs_pkg::PC_LEVEL) begin
								level_q <= lvl_wr;
							end else begin
								wdog_lim_q <= cmd.data.param_value;
							end
							wdog_cnt_q <= '0;
						end
						out_q.pwm_left      <= drive_w[0];
						out_q.pwm_right     <= drive_w[1];
						out_q.drive_written <= 1'b0;
						out_q.level_now     <= (wr_ok && cmd.data.param_code == dwvs_pkg::PC_LEVEL)
							? lvl_wr : level_q;
						out_q.timed_out     <= 1'b0;
					end else if (accept) begin
						// Control tick
						spd_q[0] <= {{16{cmd.data.speed_left[15]}}, cmd.data.speed_left};
						spd_q[1] <= {{16{cmd.data.speed_right[15]}}, cmd.data.speed_right};
						level3_q <= (level_q == dwvs_pkg::LVL_VEL);
						if (level_q != dwvs_pkg::LVL_STOP) begin
							act_q  <= act_next;
							prev_q <= act_next;
							diff_q[0] <= act_next[0] - prev_q[0];
							diff_q[1] <= act_next[1] - prev_q[1];
						end
						if (expire) begin
							flags_q    <= '0;
							wdog_cnt_q <= '0;
							wdog_lim_q <= dwvs_pkg::WDOG_RESET_LIMIT;
							level_q    <= dwvs_pkg::LVL_STOP;
						end else begin
							wdog_cnt_q <= wdog_inc;
							if (level_q != dwvs_pkg::LVL_STOP && flags_q == 2'b11)
								flags_q <= '0;
						end
						out_q.level_now <= expire ? dwvs_pkg::LVL_STOP : level_q;
						out_q.timed_out <= expire;
						step_q <= '0;
						if (level_q == dwvs_pkg::LVL_VEL) begin
							state_q <= S_PI;
						end else if (level_q == dwvs_pkg::LVL_TORQ) begin
							state_q <= S_FIN;
						end else begin
							out_q.pwm_left      <= (level_q == dwvs_pkg::LVL_STOP) ? 32'd0 : drive_w[0];
							out_q.pwm_right     <= (level_q == dwvs_pkg::LVL_STOP) ? 32'd0 : drive_w[1];
							out_q.drive_written <= (level_q == dwvs_pkg::LVL_STOP);
						end
					end
				end
				S_PI, S_MRG: begin
					if (step_q == 3'd3) begin
						step_q  <= '0;
						state_q <= (state_q == S_PI) ? S_MRG : S_FIN;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_FIN: begin
					if (step_q == 3'd6) begin
						step_q  <= '0;
						state_q <= S_OUT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_OUT: begin
					// Present the fresh drive values
					out_q.pwm_left      <= drive_w[0];
					out_q.pwm_right     <= drive_w[1];
					out_q.drive_written <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = out_v_q;
	assign res.data  = out_q;

`ifndef ASSERT_OFF
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.ready)
		else $error("item accepted while servo step in progress");
	a_timeout_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.timed_out) |-> (res.data.level_now == dwvs_pkg::LVL_STOP))
		else $error("watchdog expiry did not stop the servo");
	a_fin_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> (res.valid && res.data.drive_written))
		else $error("computed drive values not presented");
`endif

endmodule
